// ===== rtl/core/abt_pkg.sv =====
// ----------------------------------------------------------------------------
// abt_pkg
// Shared constants, state encoding and control bundles for the account
// balance transfer block.
// ----------------------------------------------------------------------------
`default_nettype none

package abt_pkg;

  // Table geometry
  localparam int ACCOUNT_COUNT = 65536;
  localparam int ACCT_ADDR_W   = $clog2(ACCOUNT_COUNT);

  // Field widths
  localparam int IDX_W = 16;
  localparam int AMT_W = 32;
  localparam int BAL_W = 64;

  // Opening balance of every account
  localparam logic [BAL_W-1:0] START_BALANCE = 64'd1000000;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_COMMIT
  } abt_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_step;  // write opening balance at the clear pointer
    logic load;        // capture request fields
    logic eval;        // check funds, write back sender
    logic commit;      // write back receiver, load response register
  } abt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;  // clear pointer sits on the last entry
    logic out_free;    // response register can take a new result
  } abt_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/abt_ram.sv =====
// ----------------------------------------------------------------------------
// abt_ram
// Generic RAM: one write port, two read ports, registered read data
// (read during write returns the old contents).
// ----------------------------------------------------------------------------
`default_nettype none

module abt_ram #(
  parameter  int WIDTH  = 64,
  parameter  int DEPTH  = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr_a,
  output logic      [WIDTH-1:0]  rdata_a,
  input  wire logic [ADDR_W-1:0] raddr_b,
  output logic      [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== rtl/core/abt_ctrl.sv =====
// ----------------------------------------------------------------------------
// abt_ctrl
// Sequencer for the transfer block: clearing pass after reset, then
// evaluate / commit per request, with the next request taken on commit.
// ----------------------------------------------------------------------------
`default_nettype none

module abt_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire abt_pkg::abt_status_t status,
  output abt_pkg::abt_cmd_t         cmd
);

  abt_pkg::abt_state_t state;
  abt_pkg::abt_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= abt_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    case (state)
      abt_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = abt_pkg::ST_IDLE;
        end
      end
      abt_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = abt_pkg::ST_EVAL;
        end
      end
      abt_pkg::ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = abt_pkg::ST_COMMIT;
      end
      abt_pkg::ST_COMMIT: begin
        // Hold until the response register frees, then take the next request
        if (status.out_free) begin
          cmd.commit = 1'b1;
          req_stall  = 1'b0;
          if (req_valid) begin
            cmd.load   = 1'b1;
            state_next = abt_pkg::ST_EVAL;
          end else begin
            state_next = abt_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = abt_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/abt_datapath.sv =====
// ----------------------------------------------------------------------------
// abt_datapath
// Balance table, funds check, write-back and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module abt_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire abt_pkg::abt_cmd_t                 cmd,
  output abt_pkg::abt_status_t                   status,
  input  wire logic [abt_pkg::IDX_W-1:0]         sender_index,
  input  wire logic [abt_pkg::IDX_W-1:0]         receiver_index,
  input  wire logic [abt_pkg::AMT_W-1:0]         amount,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_stall,
  output logic                                   accepted,
  output logic      [abt_pkg::BAL_W-1:0]         sender_balance,
  output logic      [abt_pkg::BAL_W-1:0]         receiver_balance
);

  localparam int AW = abt_pkg::ACCT_ADDR_W;
  localparam int BW = abt_pkg::BAL_W;

  // Request registers
  logic [abt_pkg::IDX_W-1:0] src_r;
  logic [abt_pkg::IDX_W-1:0] dst_r;
  logic [abt_pkg::AMT_W-1:0] amt_r;

  // Evaluate results held for commit
  logic          ok_r;
  logic          wr_dst_r;
  logic [AW-1:0] dst_addr_r;
  logic [BW-1:0] sbal_r;
  logic [BW-1:0] dbal_r;

  // Bypass of the last receiver write
  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  logic [BW-1:0] fwd_data;

  // Clear pointer
  logic [AW-1:0] clr_cnt;

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [BW-1:0] ram_wdata;
  logic [AW-1:0] raddr_src;
  logic [AW-1:0] raddr_dst;
  logic [BW-1:0] rd_src;
  logic [BW-1:0] rd_dst;

  // Evaluate logic
  logic          src_ok;
  logic          dst_ok;
  logic          same;
  logic [AW-1:0] src_addr;
  logic [AW-1:0] dst_addr;
  logic [BW-1:0] s_cur;
  logic [BW-1:0] d_cur;
  logic [BW-1:0] amt_ext;
  logic          ok;
  logic          apply;
  logic [BW-1:0] new_s;
  logic [BW-1:0] new_d;

  // Read both accounts straight from the request ports on the transfer cycle
  assign raddr_src = AW'(sender_index);
  assign raddr_dst = AW'(receiver_index);

  abt_ram #(
    .WIDTH (BW),
    .DEPTH (abt_pkg::ACCOUNT_COUNT)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (raddr_src),
    .rdata_a (rd_src),
    .raddr_b (raddr_dst),
    .rdata_b (rd_dst)
  );

  // Check funds against current balances
  always_comb begin
    src_ok   = 32'(src_r) < 32'(abt_pkg::ACCOUNT_COUNT);
    dst_ok   = 32'(dst_r) < 32'(abt_pkg::ACCOUNT_COUNT);
    same     = src_r == dst_r;
    src_addr = AW'(src_r);
    dst_addr = AW'(dst_r);
    s_cur    = (fwd_valid && fwd_addr == src_addr) ? fwd_data : rd_src;
    d_cur    = (fwd_valid && fwd_addr == dst_addr) ? fwd_data : rd_dst;
    amt_ext  = BW'(amt_r);
    ok       = src_ok && dst_ok && (s_cur >= amt_ext);
    // Self transfer leaves the balance as it was
    apply    = ok && !same;
    new_s    = apply ? (s_cur - amt_ext) : s_cur;
    new_d    = apply ? (d_cur + amt_ext) : d_cur;
  end

  // Share the write port: clear pass, sender write-back, receiver write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt;
    ram_wdata = abt_pkg::START_BALANCE;
    if (cmd.clear_step) begin
      ram_we = 1'b1;
    end else if (cmd.eval) begin
      ram_we    = apply;
      ram_waddr = src_addr;
      ram_wdata = new_s;
    end else if (cmd.commit) begin
      ram_we    = wr_dst_r;
      ram_waddr = dst_addr_r;
      ram_wdata = dbal_r;
    end
  end

  assign status.clear_last = clr_cnt == AW'(abt_pkg::ACCOUNT_COUNT - 1);
  assign status.out_free   = !rsp_valid || !rsp_stall;

  // Advance clear pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // Capture request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      src_r <= sender_index;
      dst_r <= receiver_index;
      amt_r <= amount;
    end
  end

  // Hold evaluate results for commit
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      ok_r       <= ok;
      wr_dst_r   <= apply;
      dst_addr_r <= dst_addr;
      sbal_r     <= src_ok ? new_s : '0;
      dbal_r     <= dst_ok ? new_d : '0;
    end
  end

  // Bypass the receiver write that lands on the next request's read
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= cmd.commit && wr_dst_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      fwd_addr <= dst_addr_r;
      fwd_data <= dbal_r;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      accepted         <= ok_r;
      sender_balance   <= sbal_r;
      receiver_balance <= dbal_r;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/account_balance_transfer.sv =====
// ----------------------------------------------------------------------------
// account_balance_transfer
// Table of account balances; each request moves an amount from a sender to
// a receiver when the sender's balance covers it, and returns one response.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------
//   req     | in        | req_valid / req_stall  | sender_index, receiver_index,
//           |           |                        | amount
//   rsp     | out       | rsp_valid / rsp_stall  | accepted, sender_balance,
//           |           |                        | receiver_balance
//
// After reset a clearing pass writes the opening balance into every entry,
// one per cycle, all ACCOUNT_COUNT (65536) of them; req_stall is high then.
// Each request then goes through read and evaluate, then commit; both
// write-backs go through the single write port of the balance RAM.
// A response is loaded into the response register on the commit step.
// A stalled response holds the commit step, and with it the next request.
// ----------------------------------------------------------------------------
`default_nettype none

module account_balance_transfer (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      req_valid,
  output logic                           req_stall,
  input  wire logic [abt_pkg::IDX_W-1:0] sender_index,
  input  wire logic [abt_pkg::IDX_W-1:0] receiver_index,
  input  wire logic [abt_pkg::AMT_W-1:0] amount,
  output logic                           rsp_valid,
  input  wire logic                      rsp_stall,
  output logic                           accepted,
  output logic      [abt_pkg::BAL_W-1:0] sender_balance,
  output logic      [abt_pkg::BAL_W-1:0] receiver_balance
);

  abt_pkg::abt_cmd_t    cmd;
  abt_pkg::abt_status_t status;

  abt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  abt_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .sender_index     (sender_index),
    .receiver_index   (receiver_index),
    .amount           (amount),
    .rsp_valid        (rsp_valid),
    .rsp_stall        (rsp_stall),
    .accepted         (accepted),
    .sender_balance   (sender_balance),
    .receiver_balance (receiver_balance)
  );

endmodule

`default_nettype wire

// ===== rtl/core/abt_checker.sv =====
// ----------------------------------------------------------------------------
// abt_checker
// Port-level checks on the transfer block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module abt_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      req_valid,
  input wire logic                      req_stall,
  input wire logic [abt_pkg::IDX_W-1:0] sender_index,
  input wire logic [abt_pkg::IDX_W-1:0] receiver_index,
  input wire logic [abt_pkg::AMT_W-1:0] amount,
  input wire logic                      rsp_valid,
  input wire logic                      rsp_stall,
  input wire logic                      accepted,
  input wire logic [abt_pkg::BAL_W-1:0] sender_balance,
  input wire logic [abt_pkg::BAL_W-1:0] receiver_balance
);

  logic       req_xfer;
  logic       rsp_xfer;
  logic [1:0] pending;

  assign req_xfer = req_valid && !req_stall;
  assign rsp_xfer = rsp_valid && !rsp_stall;

  // Count requests taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(req_xfer) - 2'(rsp_xfer);
    end
  end

  // Reset empties the response side
  a_rst_rsp: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // Clearing pass blocks requests right after reset
  a_clear_stall: assert property (@(posedge clk) $past(rst) |-> req_stall)
    else $error("request taken during clearing pass");

  // Requests are never taken back to back: the evaluate step stalls the port
  a_spacing: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> req_stall)
    else $error("requests taken on consecutive cycles");

  // Every response belongs to a request, and no more than two are in flight
  a_pending: assert property (@(posedge clk) disable iff (rst)
    (!rsp_valid || pending != 2'd0) && pending != 2'd3)
    else $error("response without request or too many in flight");

  // A stalled response holds its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(accepted)
      && $stable(sender_balance) && $stable(receiver_balance))
    else $error("stalled response changed");

endmodule

bind account_balance_transfer abt_checker u_abt_checker (.*);

`default_nettype wire
